FILE: rtl/sbt_pkg.sv
package sbt_pkg;

    // sizes of the obstacle table and of fractions
    localparam int MAX_BOXES = 64;
    localparam int SLOT_W    = $clog2(MAX_BOXES);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int FRAC_W    = 16;
    localparam int FRAC_OUT_W = FRAC_W + 1;
    localparam int COORD_W   = 32;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int NUM_W     = COORD_W + 2;
    localparam int DEN_W     = COORD_W + 1;
    localparam int REM_W     = COORD_W + 3;
    localparam int Q_W       = FRAC_W + 2;
    localparam int STEP_W    = $clog2(FRAC_W + 1);
    localparam int PROD_W    = DELTA_W + FRAC_OUT_W;
    localparam int IDX_W     = 3;

    localparam logic [FRAC_OUT_W-1:0] ONE_FRAC = FRAC_OUT_W'(1) << FRAC_W;
    localparam logic [CNT_W-1:0]      NO_SLOT  = CNT_W'(MAX_BOXES);

    // request kinds
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BOX   = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HMIN_X = 3'd1;
    localparam logic [IDX_W-1:0] CFG_HMIN_Y = 3'd2;
    localparam logic [IDX_W-1:0] CFG_HMIN_Z = 3'd3;
    localparam logic [IDX_W-1:0] CFG_HMAX_X = 3'd4;
    localparam logic [IDX_W-1:0] CFG_HMAX_Y = 3'd5;
    localparam logic [IDX_W-1:0] CFG_HMAX_Z = 3'd6;

    // normal codes
    localparam logic [2:0] NORM_NONE = 3'd0;
    localparam logic [2:0] NORM_NEG_X = 3'd1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t hi_z;
        coord_t hi_y;
        coord_t hi_x;
        coord_t lo_z;
        coord_t lo_y;
        coord_t lo_x;
    } box_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                    pad;
        coord_t                  stop_z;
        coord_t                  stop_y;
        coord_t                  stop_x;
        logic [CNT_W-1:0]        hit_slot;
        logic [2:0]              normal_code;
        logic [FRAC_OUT_W-1:0]   fraction;
        logic                    end_in;
        logic                    start_in;
        logic                    hit;
        logic                    accepted;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_GROW,
        ST_SOLID,
        ST_AXIS,
        ST_DIV_EN,
        ST_DIV_EX,
        ST_EVAL,
        ST_MUL,
        ST_ADD,
        ST_FIN,
        ST_OUT
    } state_t;

    // saturate a 33-bit difference to 32 bits signed
    function automatic coord_t sat32(input logic signed [DELTA_W-1:0] v);
        coord_t r;
        if (v[DELTA_W-1] != v[DELTA_W-2])
        begin
            r = v[DELTA_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/sbt_box_mem.sv
module sbt_box_mem
    import sbt_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  box_t              wr_data,
    input  logic [SLOT_W-1:0] rd_addr,
    output box_t              rd_data
);

    box_t mem [MAX_BOXES];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/sbt_div.sv
module sbt_div
    import sbt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    output logic                done,
    output logic signed [Q_W-1:0] quo
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [FRAC_OUT_W-1:0] acc_reg, acc_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic signed [Q_W-1:0] quo_reg, quo_next;

    logic [REM_W-1:0]      rem_sub;
    logic                  ge;
    logic [FRAC_OUT_W-1:0] acc_new;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
        quo_reg  <= quo_next;
    end

    // one quotient bit a cycle, result clamped to [-1, one + 1]
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        ge        = rem_reg >= {2'b00, den_reg};
        rem_sub   = ge ? rem_reg - {2'b00, den_reg} : rem_reg;
        acc_new   = {acc_reg[FRAC_OUT_W-2:0], ge};

        if (req.start)
        begin
            den_next  = req.den;
            rem_next  = {2'b00, req.num[NUM_W-2:0]};
            acc_next  = '0;
            step_next = '0;
            if (req.num[NUM_W-1])
            begin
                quo_next  = '1;
                done_next = 1'b1;
            end
            else if ({2'b00, req.num[NUM_W-2:0]} >= {1'b0, req.den, 1'b0})
            begin
                quo_next  = Q_W'(ONE_FRAC) + Q_W'(1);
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = {rem_sub[REM_W-2:0], 1'b0};
            acc_next  = acc_new;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(FRAC_W))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (acc_new > ONE_FRAC)
                begin
                    quo_next = Q_W'(ONE_FRAC) + Q_W'(1);
                end
                else
                begin
                    quo_next = {1'b0, acc_new};
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/swept_box_trace_against_boxes_top.sv
// channel   | dir | valid/ready          | payload
// s_axis    | in  | s_axis_tvalid/tready | tuser: op; tdata: slot, a_x..z, b_x..z
// m_axis    | out | m_axis_tvalid/tready | tdata: result flags, fraction, normal, slot, stop
// cfg       | in  | cfg_wr_en            | cfg_index, cfg_data
//
// a load is written from the decide state and its result is then held in the
// output state; a trace walks the table once for the main walk, using the shared
// slab divider (up to six divisions per box), then either walks it again for
// the end-inside test when the start is solid, or does a multiply and add per
// axis for the stop position on a hit.
// reset clears the sequencer and configuration registers; the box table is not cleared.
// the block takes one request at a time and holds the result until taken.
module swept_box_trace_against_boxes_top
    import sbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [199:0]       s_axis_tdata,   // slot, a_x, a_y, a_z, b_x, b_y, b_z, pad
    input  logic [1:0]         s_axis_tuser,   // op
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [127:0]       m_axis_tdata,   // accepted, hit, start inside, end inside,
                                               // fraction, normal_code, hit_slot,
                                               // stop_x, stop_y, stop_z, pad
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COORD_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [1:0]         op_reg, op_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    coord_t             a_reg [3];
    coord_t             a_next [3];
    coord_t             b_reg [3];
    coord_t             b_next [3];
    logic signed [DELTA_W-1:0] d_reg [3];
    logic signed [DELTA_W-1:0] d_next [3];
    coord_t             lo_reg [3];
    coord_t             lo_next [3];
    coord_t             hi_reg [3];
    coord_t             hi_next [3];
    coord_t             stop_reg [3];
    coord_t             stop_next [3];
    coord_t             hmin_reg [3];
    coord_t             hmax_reg [3];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [1:0]         axis_reg, axis_next;
    logic signed [Q_W-1:0] en_reg, en_next;
    logic signed [Q_W-1:0] ex_reg, ex_next;
    logic signed [Q_W-1:0] ae_reg, ae_next;
    logic [2:0]         nc_reg, nc_next;
    logic               have_reg, have_next;
    logic               dzero_reg, dzero_next;
    logic               hull_reg, hull_next;
    logic               pass_all_reg, pass_all_next;
    logic               solid_reg, solid_next;
    logic               hit_reg, hit_next;
    logic               all_reg, all_next;
    logic [FRAC_OUT_W-1:0] best_reg, best_next;
    logic [2:0]         normal_reg, normal_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    result_t            res_reg, res_next;

    logic     mem_we;
    box_t     mem_wdata;
    box_t     mem_rdata;
    div_req_t div_req;
    logic     div_done;
    logic signed [Q_W-1:0] div_quo;

    coord_t   rd_lo [3];
    coord_t   rd_hi [3];
    logic     in_a;
    logic     in_b;
    logic     hull_ok;
    logic     load_ok;
    logic signed [DELTA_W-1:0] d_ax;
    coord_t   a_ax;
    coord_t   lo_ax;
    coord_t   hi_ax;
    logic signed [Q_W-1:0] en_new;
    logic signed [Q_W-1:0] ex_new;
    logic signed [PROD_W-1:0] prod_sh;

    // box table
    sbt_box_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (slot_reg),
        .wr_data (mem_wdata),
        .rd_addr (k_reg[SLOT_W-1:0]),
        .rd_data (mem_rdata)
    );

    // shared slab divider
    sbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                hmin_reg[i] <= '0;
                hmax_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_COUNT:  count_reg   <= cfg_data[CNT_W-1:0];
                CFG_HMIN_X: hmin_reg[0] <= cfg_data;
                CFG_HMIN_Y: hmin_reg[1] <= cfg_data;
                CFG_HMIN_Z: hmin_reg[2] <= cfg_data;
                CFG_HMAX_X: hmax_reg[0] <= cfg_data;
                CFG_HMAX_Y: hmax_reg[1] <= cfg_data;
                CFG_HMAX_Z: hmax_reg[2] <= cfg_data;
                default:    count_reg   <= count_reg;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        k_reg        <= k_next;
        axis_reg     <= axis_next;
        en_reg       <= en_next;
        ex_reg       <= ex_next;
        ae_reg       <= ae_next;
        nc_reg       <= nc_next;
        have_reg     <= have_next;
        dzero_reg    <= dzero_next;
        hull_reg     <= hull_next;
        pass_all_reg <= pass_all_next;
        solid_reg    <= solid_next;
        hit_reg      <= hit_next;
        all_reg      <= all_next;
        best_reg     <= best_next;
        normal_reg   <= normal_next;
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        for (int i = 0; i < 3; i++)
        begin
            a_reg[i]    <= a_next[i];
            b_reg[i]    <= b_next[i];
            d_reg[i]    <= d_next[i];
            lo_reg[i]   <= lo_next[i];
            hi_reg[i]   <= hi_next[i];
            stop_reg[i] <= stop_next[i];
        end
    end

    // read port fields and per-axis selection
    always_comb
    begin
        rd_lo[0] = mem_rdata.lo_x;
        rd_lo[1] = mem_rdata.lo_y;
        rd_lo[2] = mem_rdata.lo_z;
        rd_hi[0] = mem_rdata.hi_x;
        rd_hi[1] = mem_rdata.hi_y;
        rd_hi[2] = mem_rdata.hi_z;
        d_ax  = d_reg[axis_reg];
        a_ax  = a_reg[axis_reg];
        lo_ax = lo_reg[axis_reg];
        hi_ax = hi_reg[axis_reg];
        in_a    = 1'b1;
        in_b    = 1'b1;
        hull_ok = 1'b1;
        load_ok = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            in_a    = in_a & (a_reg[i] > lo_reg[i]) & (a_reg[i] < hi_reg[i]);
            in_b    = in_b & (b_reg[i] > lo_reg[i]) & (b_reg[i] < hi_reg[i]);
            hull_ok = hull_ok & (hmin_reg[i] < hmax_reg[i]);
            load_ok = load_ok & (a_reg[i] < b_reg[i]);
        end
        mem_wdata.lo_x = a_reg[0];
        mem_wdata.lo_y = a_reg[1];
        mem_wdata.lo_z = a_reg[2];
        mem_wdata.hi_x = b_reg[0];
        mem_wdata.hi_y = b_reg[1];
        mem_wdata.hi_z = b_reg[2];
        en_new = (!have_reg || ae_reg > en_reg) ? ae_reg : en_reg;
        ex_new = (!have_reg || div_quo < ex_reg) ? div_quo : ex_reg;
        prod_sh = prod_reg >>> FRAC_W;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        k_next        = k_reg;
        axis_next     = axis_reg;
        en_next       = en_reg;
        ex_next       = ex_reg;
        ae_next       = ae_reg;
        nc_next       = nc_reg;
        have_next     = have_reg;
        dzero_next    = dzero_reg;
        hull_next     = hull_reg;
        pass_all_next = pass_all_reg;
        solid_next    = solid_reg;
        hit_next      = hit_reg;
        all_next      = all_reg;
        best_next     = best_reg;
        normal_next   = normal_reg;
        idx_next      = idx_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        for (int i = 0; i < 3; i++)
        begin
            a_next[i]    = a_reg[i];
            b_next[i]    = b_reg[i];
            d_next[i]    = d_reg[i];
            lo_next[i]   = lo_reg[i];
            hi_next[i]   = hi_reg[i];
            stop_next[i] = stop_reg[i];
        end
        mem_we        = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        s_axis_tready = 1'b0;

        case (state_reg)
            // take a request
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                op_next   = s_axis_tuser;
                slot_next = s_axis_tdata[SLOT_W-1:0];
                for (int i = 0; i < 3; i++)
                begin
                    a_next[i] = s_axis_tdata[SLOT_W + COORD_W*i +: COORD_W];
                    b_next[i] = s_axis_tdata[SLOT_W + COORD_W*(i+3) +: COORD_W];
                end
                if (s_axis_tvalid)
                begin
                    state_next = ST_DECIDE;
                end
            end

            // loads, refusals and trace setup
            ST_DECIDE:
            begin
                res_next          = '0;
                res_next.hit_slot = NO_SLOT;
                k_next            = '0;
                solid_next        = 1'b0;
                hit_next          = 1'b0;
                all_next          = 1'b0;
                best_next         = ONE_FRAC;
                normal_next       = NORM_NONE;
                idx_next          = NO_SLOT;
                pass_all_next     = 1'b0;
                hull_next         = (op_reg == OP_BOX);
                dzero_next        = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    d_next[i]  = DELTA_W'(b_reg[i]) - DELTA_W'(a_reg[i]);
                    dzero_next = dzero_next & (a_reg[i] == b_reg[i]);
                end
                if (op_reg == OP_LOAD)
                begin
                    mem_we            = load_ok;
                    res_next.accepted = load_ok;
                    state_next        = ST_OUT;
                end
                else if (op_reg == OP_NONE || count_reg > CNT_W'(MAX_BOXES) ||
                         (op_reg == OP_BOX && !hull_ok))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            // table read issued for slot k, or end of a walk
            ST_READ:
            begin
                if (k_reg == count_reg)
                begin
                    axis_next = '0;
                    if (pass_all_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (solid_reg)
                    begin
                        pass_all_next = 1'b1;
                        k_next        = '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            stop_next[i] = a_reg[i];
                        end
                    end
                    else if (hit_reg)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            stop_next[i] = b_reg[i];
                        end
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    state_next = ST_GROW;
                end
            end

            // grow the obstacle by the hull
            ST_GROW:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lo_next[i] = sat32(DELTA_W'(rd_lo[i]) -
                                       DELTA_W'(hull_reg ? hmax_reg[i] : coord_t'(0)));
                    hi_next[i] = sat32(DELTA_W'(rd_hi[i]) -
                                       DELTA_W'(hull_reg ? hmin_reg[i] : coord_t'(0)));
                end
                state_next = ST_SOLID;
            end

            // containment tests
            ST_SOLID:
            begin
                axis_next = '0;
                have_next = 1'b0;
                k_next    = k_reg + CNT_W'(1);
                state_next = ST_READ;
                if (pass_all_reg)
                begin
                    if (in_b)
                    begin
                        all_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                end
                else if (in_a)
                begin
                    if (!solid_reg)
                    begin
                        idx_next = k_reg;
                    end
                    solid_next  = 1'b1;
                    hit_next    = 1'b1;
                    best_next   = '0;
                    normal_next = NORM_NONE;
                end
                else if (!solid_reg && !dzero_reg)
                begin
                    k_next     = k_reg;
                    state_next = ST_AXIS;
                end
            end

            // one slab: flat axis test or entry division
            ST_AXIS:
            begin
                if (d_ax == '0)
                begin
                    if (!(a_ax > lo_ax && a_ax < hi_ax))
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_READ;
                    end
                    else if (axis_reg == 2'd2)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.den   = d_ax[DELTA_W-1] ? DEN_W'(-d_ax) : DEN_W'(d_ax);
                    div_req.num   = d_ax[DELTA_W-1] ?
                                    NUM_W'(a_ax) - NUM_W'(hi_ax) :
                                    NUM_W'(lo_ax) - NUM_W'(a_ax);
                    state_next    = ST_DIV_EN;
                end
            end

            // entry time back, start exit division
            ST_DIV_EN:
            begin
                if (div_done)
                begin
                    ae_next       = div_quo;
                    div_req.start = 1'b1;
                    div_req.den   = d_ax[DELTA_W-1] ? DEN_W'(-d_ax) : DEN_W'(d_ax);
                    div_req.num   = d_ax[DELTA_W-1] ?
                                    NUM_W'(a_ax) - NUM_W'(lo_ax) :
                                    NUM_W'(hi_ax) - NUM_W'(a_ax);
                    state_next    = ST_DIV_EX;
                end
            end

            // exit time back, merge into the interval
            ST_DIV_EX:
            begin
                if (div_done)
                begin
                    en_next   = en_new;
                    ex_next   = ex_new;
                    have_next = 1'b1;
                    if (!have_reg || ae_reg > en_reg)
                    begin
                        nc_next = NORM_NEG_X + {axis_reg, 1'b0} + {2'b00, d_ax[DELTA_W-1]};
                    end
                    if (en_new > ex_new)
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_READ;
                    end
                    else if (axis_reg == 2'd2)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_AXIS;
                    end
                end
            end

            // keep the earliest hit
            ST_EVAL:
            begin
                if (en_reg >= 0 && en_reg <= $signed(Q_W'(ONE_FRAC)) &&
                    (hull_reg ? en_reg[FRAC_OUT_W-1:0] < best_reg :
                     (!hit_reg || en_reg[FRAC_OUT_W-1:0] < best_reg)))
                begin
                    hit_next    = 1'b1;
                    best_next   = en_reg[FRAC_OUT_W-1:0];
                    normal_next = nc_reg;
                    idx_next    = k_reg;
                end
                k_next     = k_reg + CNT_W'(1);
                state_next = ST_READ;
            end

            // stop position: delta times fraction
            ST_MUL:
            begin
                prod_next  = PROD_W'(d_ax) * $signed(PROD_W'({1'b0, best_reg}));
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                stop_next[axis_reg] = a_ax + prod_sh[COORD_W-1:0];
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end

            // build the trace result
            ST_FIN:
            begin
                res_next.pad         = 1'b0;
                res_next.accepted    = 1'b1;
                res_next.hit         = hit_reg;
                res_next.start_in    = solid_reg;
                res_next.end_in      = all_reg;
                res_next.fraction    = best_reg;
                res_next.normal_code = normal_reg;
                res_next.hit_slot    = idx_reg;
                res_next.stop_x      = stop_reg[0];
                res_next.stop_y      = stop_reg[1];
                res_next.stop_z      = stop_reg[2];
                state_next           = ST_OUT;
            end

            // hold the result until taken
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = res_reg;

endmodule
